/* rtl/rsch_pkg.sv */
// Package for the ray/sphere closest-hit block: widths, codes, shared types.
// No dependencies; every other file of the block uses it.
`default_nettype none

package rsch_pkg;

  // Item fields
  localparam int COORD_W     = 40;
  localparam int IDX_W       = 2;
  localparam int RAD_W       = 16;
  localparam int NUM_SPHERES = 4;
  localparam int FRAC_BITS   = 16;

  // Datapath widths: operand magnitudes stay below 2^MAG_W
  localparam int OC_W   = COORD_W + 1;
  localparam int MAG_W  = 84;
  localparam int MUL_W  = MAG_W + 1;
  localparam int ACC_W  = 2 * MAG_W + 2;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int NUM_W  = MAG_W + 2;
  localparam int DIVN_W = MAG_W + FRAC_BITS;
  localparam int T_W    = DIVN_W + 1;
  localparam int SPH_W  = $clog2(NUM_SPHERES + 1);

  // Far distance and the no-hit value shown on the port
  localparam logic [63:0] INF_VAL   = 64'd100000 << FRAC_BITS;
  localparam logic [63:0] MAX_COORD = (64'd1 << (COORD_W - 1)) - 64'd1;
  localparam logic [COORD_W-1:0] NOHIT_DIST =
    (INF_VAL > MAX_COORD) ? MAX_COORD[COORD_W-1:0] : INF_VAL[COORD_W-1:0];

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_CAST  = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic [RAD_W-1:0]          radius;
  } sphere_t;

  typedef struct packed {
    logic                    start;
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic            start;
    logic [SQ_W-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic              start;
    logic [DIVN_W-1:0] num;
    logic [MAG_W-1:0]  den;
  } div_req_t;

  typedef enum logic [3:0] {
    OP_DXX, OP_DYY, OP_DZZ,
    OP_OXD, OP_OYD, OP_OZD,
    OP_OXX, OP_OYY, OP_OZZ,
    OP_RR, OP_K2K2, OP_K1K3
  } mul_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_ISSUE,
    ST_MUL_WAIT,
    ST_K1_CHECK,
    ST_SPHERE,
    ST_DISC_CHECK,
    ST_SQRT_WAIT,
    ST_DIV_ISSUE,
    ST_DIV_WAIT,
    ST_NEXT,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

/* rtl/rsch_if.sv */
// Valid/ready channel interfaces for item and result beats.
// Depends on rsch_pkg for field widths.
`default_nettype none

interface rsch_item_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   func;
  logic [rsch_pkg::IDX_W-1:0]             entry_index;
  logic signed [rsch_pkg::COORD_W-1:0]    point_x;
  logic signed [rsch_pkg::COORD_W-1:0]    point_y;
  logic signed [rsch_pkg::COORD_W-1:0]    point_z;
  logic signed [rsch_pkg::COORD_W-1:0]    dir_x;
  logic signed [rsch_pkg::COORD_W-1:0]    dir_y;
  logic signed [rsch_pkg::COORD_W-1:0]    dir_z;
  logic [rsch_pkg::RAD_W-1:0]             radius;
  logic signed [rsch_pkg::COORD_W-1:0]    min_t;
  logic signed [rsch_pkg::COORD_W-1:0]    max_t;

  modport source (output valid, func, entry_index, point_x, point_y, point_z,
                  dir_x, dir_y, dir_z, radius, min_t, max_t, input ready);
  modport sink   (input valid, func, entry_index, point_x, point_y, point_z,
                  dir_x, dir_y, dir_z, radius, min_t, max_t, output ready);
endinterface

interface rsch_result_if;
  logic                                valid;
  logic                                ready;
  logic                                hit;
  logic [rsch_pkg::IDX_W-1:0]          hit_index;
  logic signed [rsch_pkg::COORD_W-1:0] distance;

  modport source (output valid, hit, hit_index, distance, input ready);
  modport sink   (input valid, hit, hit_index, distance, output ready);
endinterface

`default_nettype wire

/* rtl/rsch_cell.sv */
// One sphere table cell of the rotating ring.
// Depends on rsch_pkg.
`default_nettype none

module rsch_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  rsch_pkg::sphere_t wr_data_i,
  input  logic              shift_i,
  input  rsch_pkg::sphere_t nb_data_i,
  input  logic              nb_valid_i,
  output rsch_pkg::sphere_t data_o,
  output logic              valid_o
);
  import rsch_pkg::*;

  sphere_t data_q;
  logic    valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (wr_en_i) begin
      valid_q <= 1'b1;
    end else if (shift_i) begin
      valid_q <= nb_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      data_q <= wr_data_i;
    end else if (shift_i) begin
      data_q <= nb_data_i;
    end
  end

  assign data_o  = data_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

/* rtl/rsch_mul.sv */
// Shift-add signed multiplier, one multiplier bit per cycle.
// Depends on rsch_pkg.
`default_nettype none

module rsch_mul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rsch_pkg::mul_req_t                  req_i,
  output logic                                done_o,
  output logic signed [rsch_pkg::ACC_W-1:0]   prod_o
);
  import rsch_pkg::*;

  logic                   busy_q, done_q;
  logic [2*MAG_W-1:0]     mcand_q, acc_q;
  logic [MAG_W-1:0]       mplier_q;
  logic                   neg_q;
  logic signed [ACC_W-1:0] prod_q;
  logic [MUL_W-1:0]       a_abs, b_abs;
  logic [ACC_W-1:0]       p_ext;
  logic                   finish;

  assign a_abs  = req_i.a[MUL_W-1] ? -req_i.a : req_i.a;
  assign b_abs  = req_i.b[MUL_W-1] ? -req_i.b : req_i.b;
  assign p_ext  = {2'b00, acc_q};
  assign finish = busy_q && (mplier_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= finish;
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (finish) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mcand_q  <= (2*MAG_W)'(a_abs[MAG_W-1:0]);
      mplier_q <= b_abs[MAG_W-1:0];
      acc_q    <= '0;
      neg_q    <= req_i.a[MUL_W-1] ^ req_i.b[MUL_W-1];
    end else if (finish) begin
      prod_q <= neg_q ? -p_ext : p_ext;
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        acc_q <= acc_q + mcand_q;
      end
      mcand_q  <= {mcand_q[2*MAG_W-2:0], 1'b0};
      mplier_q <= {1'b0, mplier_q[MAG_W-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

`default_nettype wire

/* rtl/rsch_sqrt.sv */
// Digit-by-digit floor square root, one root bit per cycle.
// Depends on rsch_pkg.
`default_nettype none

module rsch_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rsch_pkg::sqrt_req_t           req_i,
  output logic                          done_o,
  output logic [rsch_pkg::MAG_W-1:0]    root_o
);
  import rsch_pkg::*;

  localparam int CNT_W = $clog2(MAG_W + 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [SQ_W-1:0]  x_q;
  logic [MAG_W-1:0] root_q;
  logic [MAG_W+1:0] rem_q;
  logic [MAG_W+3:0] rem_sh, trial, rem_diff;
  logic             ge;
  logic             last;

  assign rem_sh   = {rem_q, x_q[SQ_W-1 -: 2]};
  assign trial    = (MAG_W+4)'({root_q, 2'b01});
  assign rem_diff = rem_sh - trial;
  assign ge       = rem_sh >= trial;
  assign last     = cnt_q == CNT_W'(MAG_W - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q    <= req_i.radicand;
      root_q <= '0;
      rem_q  <= '0;
    end else if (busy_q) begin
      x_q    <= {x_q[SQ_W-3:0], 2'b00};
      rem_q  <= ge ? rem_diff[MAG_W+1:0] : rem_sh[MAG_W+1:0];
      root_q <= {root_q[MAG_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

/* rtl/rsch_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on rsch_pkg.
`default_nettype none

module rsch_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rsch_pkg::div_req_t            req_i,
  output logic                          done_o,
  output logic [rsch_pkg::DIVN_W-1:0]   quot_o
);
  import rsch_pkg::*;

  localparam int CNT_W = $clog2(DIVN_W + 1);

  logic              busy_q, done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DIVN_W-1:0] n_q;
  logic [MAG_W-1:0]  den_q, rem_q;
  logic [MAG_W:0]    rem_sh, diff;
  logic              ge;
  logic              last;

  assign rem_sh = {rem_q, n_q[DIVN_W-1]};
  assign diff   = rem_sh - {1'b0, den_q};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign last   = cnt_q == CNT_W'(DIVN_W - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      n_q   <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[MAG_W-1:0] : rem_sh[MAG_W-1:0];
      n_q   <= {n_q[DIVN_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = n_q;

endmodule

`default_nettype wire

/* rtl/ray_sphere_closest_hit.sv */
// Top level of the ray/sphere closest-hit block.
// Depends on rsch_pkg, rsch_if, rsch_cell, rsch_mul, rsch_sqrt, rsch_div.
`default_nettype none

// A write beat (func 0) stores a sphere's center and integer radius in the
// ring entry named by entry_index and marks it valid; it gives no result.
// A cast beat (func 1) solves k1 t^2 + k2 t + k3 = 0 for every valid
// sphere in index order, in wide fixed point, and returns one result beat:
// hit, hit_index and the nearest t strictly inside (min_t, max_t), or the
// far distance when nothing is hit. The block takes one beat at a time. A
// cast costs 3 multiplies, then per valid sphere 9 multiplies, a square
// root and two divides; a sphere ruled out by its discriminant skips the
// square root and the divides. The sphere table is a ring of cells that
// rotates once per cast with a nonzero direction to bring each entry to the
// head; reset clears only the valid bits. A finished result waits in an
// output register so a write beat may enter while the result is still
// pending.
module ray_sphere_closest_hit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  rsch_item_if.sink            item_i,
  rsch_result_if.source        result_o
);
  import rsch_pkg::*;

  state_e state_q, state_d;
  mul_op_e op_q;
  logic             root_sel_q;
  logic [SPH_W-1:0] sph_q;
  logic [IDX_W-1:0] hidx_q, hit_idx_q;
  logic             hit_q;
  logic             out_valid_q;

  // ray operands
  logic signed [COORD_W-1:0] org_x_q, org_y_q, org_z_q;
  logic signed [COORD_W-1:0] dir_x_q, dir_y_q, dir_z_q;
  logic signed [COORD_W-1:0] lo_q, hi_q;
  logic signed [OC_W-1:0]    ox_q, oy_q, oz_q;

  // quadratic accumulators
  logic signed [ACC_W-1:0] k1_q, h_q, k3_q, disc_q;
  logic                    num_neg_q;
  logic signed [T_W-1:0]   closest_q;

  logic                      out_hit_q;
  logic [IDX_W-1:0]          out_idx_q;
  logic signed [COORD_W-1:0] out_dist_q;

  // sphere ring
  sphere_t cell_data [NUM_SPHERES];
  logic    cell_vld  [NUM_SPHERES];
  sphere_t wr_data;
  logic    ring_shift;
  logic    item_acc, is_write;

  // arithmetic units
  mul_req_t               mul_req;
  logic                   mul_done;
  logic signed [ACC_W-1:0] prod;
  sqrt_req_t              sqrt_req;
  logic                   sqrt_done;
  logic [MAG_W-1:0]       sq_root;
  div_req_t               div_req;
  logic                   div_done;
  logic [DIVN_W-1:0]      quot;

  logic signed [MUL_W-1:0] k2_op, k1_op, k3_op, rr_op;
  logic signed [NUM_W-1:0] k2_n, s_n, num;
  logic [NUM_W-1:0]        num_mag;
  logic signed [T_W-1:0]   t_w, lo_w, hi_w;
  logic                    take_t;
  logic                    last_sph;
  logic                    out_free;

  assign item_acc = item_i.valid && item_i.ready;
  assign is_write = item_i.func == FUNC_WRITE;
  assign out_free = !out_valid_q || result_o.ready;
  assign last_sph = sph_q == SPH_W'(NUM_SPHERES - 1);

  assign wr_data.cx     = item_i.point_x;
  assign wr_data.cy     = item_i.point_y;
  assign wr_data.cz     = item_i.point_z;
  assign wr_data.radius = item_i.radius;

  for (genvar i = 0; i < NUM_SPHERES; i++) begin : g_ring
    rsch_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .wr_en_i    (item_acc && is_write && (32'(item_i.entry_index) == i)),
      .wr_data_i  (wr_data),
      .shift_i    (ring_shift),
      .nb_data_i  (cell_data[(i + 1) % NUM_SPHERES]),
      .nb_valid_i (cell_vld[(i + 1) % NUM_SPHERES]),
      .data_o     (cell_data[i]),
      .valid_o    (cell_vld[i])
    );
  end

  rsch_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (prod)
  );

  rsch_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sqrt_req),
    .done_o (sqrt_done),
    .root_o (sq_root)
  );

  rsch_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (quot)
  );

  // derived operands; all values stay well inside the operand width
  assign k2_op = {h_q[MUL_W-2:0], 1'b0};
  assign k1_op = k1_q[MUL_W-1:0];
  assign k3_op = k3_q[MUL_W-1:0];
  assign rr_op = MUL_W'({cell_data[0].radius, {FRAC_BITS{1'b0}}});

  // root numerator: -k2 + s first, then -k2 - s
  assign k2_n    = NUM_W'(k2_op);
  assign s_n     = NUM_W'({1'b0, sq_root});
  assign num     = root_sel_q ? (-k2_n - s_n) : (-k2_n + s_n);
  assign num_mag = num[NUM_W-1] ? -num : num;

  // signed root and window test
  assign t_w    = num_neg_q ? -T_W'(quot) : T_W'(quot);
  assign lo_w   = T_W'(lo_q);
  assign hi_w   = T_W'(hi_q);
  assign take_t = (t_w < closest_q) && (lo_w < t_w) && (t_w < hi_w);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (item_acc && !is_write) begin
          state_d = ST_MUL_ISSUE;
        end
      end
      ST_MUL_ISSUE: state_d = ST_MUL_WAIT;
      ST_MUL_WAIT: begin
        if (mul_done) begin
          if (op_q == OP_DZZ) begin
            state_d = ST_K1_CHECK;
          end else if (op_q == OP_K1K3) begin
            state_d = ST_DISC_CHECK;
          end else begin
            state_d = ST_MUL_ISSUE;
          end
        end
      end
      ST_K1_CHECK: state_d = (k1_q == '0) ? ST_OUT : ST_SPHERE;
      ST_SPHERE: state_d = cell_vld[0] ? ST_MUL_ISSUE : ST_NEXT;
      ST_DISC_CHECK: state_d = disc_q[ACC_W-1] ? ST_NEXT : ST_SQRT_WAIT;
      ST_SQRT_WAIT: begin
        if (sqrt_done) begin
          state_d = ST_DIV_ISSUE;
        end
      end
      ST_DIV_ISSUE: state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_d = root_sel_q ? ST_NEXT : ST_DIV_ISSUE;
        end
      end
      ST_NEXT: state_d = last_sph ? ST_OUT : ST_SPHERE;
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // unit strobes and operand selection
  always_comb begin
    item_i.ready      = state_q == ST_IDLE;
    ring_shift        = state_q == ST_NEXT;
    mul_req.start     = state_q == ST_MUL_ISSUE;
    mul_req.a         = MUL_W'(dir_x_q);
    mul_req.b         = MUL_W'(dir_x_q);
    sqrt_req.start    = (state_q == ST_DISC_CHECK) && !disc_q[ACC_W-1];
    sqrt_req.radicand = disc_q[SQ_W-1:0];
    div_req.start     = state_q == ST_DIV_ISSUE;
    div_req.num       = {num_mag[MAG_W-1:0], {FRAC_BITS{1'b0}}};
    div_req.den       = {k1_q[MAG_W-2:0], 1'b0};
    case (op_q)
      OP_DXX: begin
        mul_req.a = MUL_W'(dir_x_q);
        mul_req.b = MUL_W'(dir_x_q);
      end
      OP_DYY: begin
        mul_req.a = MUL_W'(dir_y_q);
        mul_req.b = MUL_W'(dir_y_q);
      end
      OP_DZZ: begin
        mul_req.a = MUL_W'(dir_z_q);
        mul_req.b = MUL_W'(dir_z_q);
      end
      OP_OXD: begin
        mul_req.a = MUL_W'(ox_q);
        mul_req.b = MUL_W'(dir_x_q);
      end
      OP_OYD: begin
        mul_req.a = MUL_W'(oy_q);
        mul_req.b = MUL_W'(dir_y_q);
      end
      OP_OZD: begin
        mul_req.a = MUL_W'(oz_q);
        mul_req.b = MUL_W'(dir_z_q);
      end
      OP_OXX: begin
        mul_req.a = MUL_W'(ox_q);
        mul_req.b = MUL_W'(ox_q);
      end
      OP_OYY: begin
        mul_req.a = MUL_W'(oy_q);
        mul_req.b = MUL_W'(oy_q);
      end
      OP_OZZ: begin
        mul_req.a = MUL_W'(oz_q);
        mul_req.b = MUL_W'(oz_q);
      end
      OP_RR: begin
        mul_req.a = rr_op;
        mul_req.b = rr_op;
      end
      OP_K2K2: begin
        mul_req.a = k2_op;
        mul_req.b = k2_op;
      end
      OP_K1K3: begin
        mul_req.a = k1_op;
        mul_req.b = k3_op;
      end
      default: begin
        mul_req.a = MUL_W'(dir_x_q);
        mul_req.b = MUL_W'(dir_x_q);
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_DXX;
      root_sel_q  <= 1'b0;
      sph_q       <= '0;
      hidx_q      <= '0;
      hit_q       <= 1'b0;
      hit_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          op_q      <= OP_DXX;
          sph_q     <= '0;
          hidx_q    <= '0;
          hit_q     <= 1'b0;
          hit_idx_q <= '0;
        end
        ST_MUL_WAIT: begin
          if (mul_done) begin
            case (op_q)
              OP_DXX:  op_q <= OP_DYY;
              OP_DYY:  op_q <= OP_DZZ;
              OP_OXD:  op_q <= OP_OYD;
              OP_OYD:  op_q <= OP_OZD;
              OP_OZD:  op_q <= OP_OXX;
              OP_OXX:  op_q <= OP_OYY;
              OP_OYY:  op_q <= OP_OZZ;
              OP_OZZ:  op_q <= OP_RR;
              OP_RR:   op_q <= OP_K2K2;
              OP_K2K2: op_q <= OP_K1K3;
              default: op_q <= op_q;
            endcase
          end
        end
        ST_SPHERE: op_q <= OP_OXD;
        ST_DISC_CHECK: root_sel_q <= 1'b0;
        ST_DIV_WAIT: begin
          if (div_done) begin
            root_sel_q <= 1'b1;
            if (take_t) begin
              hit_q     <= 1'b1;
              hit_idx_q <= hidx_q;
            end
          end
        end
        ST_NEXT: begin
          sph_q  <= sph_q + 1'b1;
          hidx_q <= hidx_q + 1'b1;
        end
        default: begin
        end
      endcase
      // result register: load on leaving ST_OUT, clear when taken
      if ((state_q == ST_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (item_acc && !is_write) begin
          org_x_q   <= item_i.point_x;
          org_y_q   <= item_i.point_y;
          org_z_q   <= item_i.point_z;
          dir_x_q   <= item_i.dir_x;
          dir_y_q   <= item_i.dir_y;
          dir_z_q   <= item_i.dir_z;
          lo_q      <= item_i.min_t;
          hi_q      <= item_i.max_t;
          k1_q      <= '0;
          closest_q <= T_W'(INF_VAL);
        end
      end
      ST_SPHERE: begin
        ox_q <= OC_W'(org_x_q) - OC_W'(cell_data[0].cx);
        oy_q <= OC_W'(org_y_q) - OC_W'(cell_data[0].cy);
        oz_q <= OC_W'(org_z_q) - OC_W'(cell_data[0].cz);
        h_q  <= '0;
        k3_q <= '0;
      end
      ST_MUL_WAIT: begin
        if (mul_done) begin
          case (op_q)
            OP_DXX, OP_DYY, OP_DZZ: k1_q <= k1_q + prod;
            OP_OXD, OP_OYD, OP_OZD: h_q  <= h_q + prod;
            OP_OXX, OP_OYY, OP_OZZ: k3_q <= k3_q + prod;
            OP_RR:   k3_q   <= k3_q - prod;
            OP_K2K2: disc_q <= prod;
            OP_K1K3: disc_q <= disc_q - {prod[ACC_W-3:0], 2'b00};
            default: begin
            end
          endcase
        end
      end
      ST_DIV_ISSUE: num_neg_q <= num[NUM_W-1];
      ST_DIV_WAIT: begin
        if (div_done && take_t) begin
          closest_q <= t_w;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_hit_q  <= hit_q;
          out_idx_q  <= hit_idx_q;
          out_dist_q <= hit_q ? closest_q[COORD_W-1:0] : NOHIT_DIST;
        end
      end
      default: begin
      end
    endcase
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.hit       = out_hit_q;
  assign result_o.hit_index = out_idx_q;
  assign result_o.distance  = out_dist_q;

endmodule

`default_nettype wire
